/* design/trd_pkg.sv */
// shared types and constants for the tga run-length pixel decoder
// no dependencies; imported by trd_cfg_if and every module of the block
package trd_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PIXELS = 8'd1;

    // reset values of the configuration registers
    localparam logic [2:0]  PIXEL_BYTES_RESET  = 3'd4;
    localparam logic [31:0] TOTAL_PIXELS_RESET = 32'd1;

    localparam logic [2:0] PIXEL_BYTES_24 = 3'd3;
    localparam logic [7:0] RUN_FLAG_HDR   = 8'd128;
    localparam logic [7:0] RUN_BIAS       = 8'd127;
    localparam logic [7:0] OPAQUE_ALPHA   = 8'hFF;

    typedef struct packed {
        logic [2:0]  pixel_bytes;
        logic [31:0] total_pixels;
    } trd_cfg_t;

    // one finished pixel waiting between front and back
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] byte2;
        logic [7:0] last_byte;
        logic       three_byte;
        logic [7:0] repeat_count;
        logic       image_done;
    } trd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } trd_q_stat_t;

endpackage

/* design/trd_ifs.sv */
// handshake channels of the tga run-length pixel decoder
// depends on trd_pkg for widths
interface trd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface trd_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output repeat_count, output image_done, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input repeat_count, input image_done, output ready);
endinterface

interface trd_cfg_if
    import trd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/trd_front.sv */
// front end: takes coded bytes, tracks packets, assembles pixels, counts image pixels
// depends on trd_pkg and trd_byte_if; pushes finished pixels into the queue
module trd_front
    import trd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  trd_cfg_t      cfg,
    trd_byte_if.sink      in_ch,
    input  logic          q_full,
    output logic          push,
    output trd_item_t     push_item
);

    logic        in_packet_reg, in_packet_next;
    logic        is_run_reg, is_run_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [23:0] asm_reg, asm_next;
    logic [31:0] decoded_reg, decoded_next;

    logic        accept;
    logic [1:0]  last_idx;
    logic [31:0] total_eff;
    logic [32:0] diff;
    logic [31:0] remaining;
    logic [7:0]  rep_req;
    logic        done;
    logic [7:0]  rep;

    assign in_ch.ready = ~q_full;
    assign accept      = in_ch.valid & ~q_full;

    always_comb
    begin
        last_idx  = (cfg.pixel_bytes == PIXEL_BYTES_24) ? 2'd2 : 2'd3;
        total_eff = (cfg.total_pixels == 32'd0) ? 32'd1 : cfg.total_pixels;
        diff      = {1'b0, total_eff} - {1'b0, decoded_reg};
        // total at or below count already decoded: one more pixel ends the image
        remaining = (diff[32] || diff[31:0] == 32'd0) ? 32'd1 : diff[31:0];
        rep_req   = is_run_reg ? left_reg : 8'd1;
        if (rep_req == 8'd0)
        begin
            rep_req = 8'd1;
        end
        done = (remaining <= {24'd0, rep_req});
        rep  = done ? remaining[7:0] : rep_req;
    end

    always_comb
    begin
        in_packet_next = in_packet_reg;
        is_run_next    = is_run_reg;
        left_next      = left_reg;
        byte_idx_next  = byte_idx_reg;
        asm_next       = asm_reg;
        decoded_next   = decoded_reg;
        push           = 1'b0;

        push_item.blue         = asm_reg[7:0];
        push_item.green        = asm_reg[15:8];
        push_item.byte2        = asm_reg[23:16];
        push_item.last_byte    = in_ch.data_byte;
        push_item.three_byte   = (last_idx == 2'd2);
        push_item.repeat_count = rep;
        push_item.image_done   = done;

        if (accept)
        begin
            if (!in_packet_reg)
            begin
                // packet header
                is_run_next    = (in_ch.data_byte >= RUN_FLAG_HDR);
                left_next      = is_run_next ? (in_ch.data_byte - RUN_BIAS)
                                             : (in_ch.data_byte + 8'd1);
                in_packet_next = 1'b1;
                byte_idx_next  = 2'd0;
                asm_next       = 24'd0;
            end
            else if (byte_idx_reg < last_idx)
            begin
                asm_next[byte_idx_reg*8 +: 8] = in_ch.data_byte;
                byte_idx_next = byte_idx_reg + 2'd1;
            end
            else
            begin
                push          = 1'b1;
                byte_idx_next = 2'd0;
                asm_next      = 24'd0;
                if (done)
                begin
                    in_packet_next = 1'b0;
                    is_run_next    = 1'b0;
                    left_next      = 8'd0;
                    decoded_next   = 32'd0;
                end
                else
                begin
                    decoded_next = decoded_reg + {24'd0, rep};
                    if (is_run_reg || left_reg <= 8'd1)
                    begin
                        left_next      = 8'd0;
                        in_packet_next = 1'b0;
                    end
                    else
                    begin
                        left_next = left_reg - 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            is_run_reg    <= 1'b0;
            left_reg      <= 8'd0;
            byte_idx_reg  <= 2'd0;
            asm_reg       <= 24'd0;
            decoded_reg   <= 32'd0;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            is_run_reg    <= is_run_next;
            left_reg      <= left_next;
            byte_idx_reg  <= byte_idx_next;
            asm_reg       <= asm_next;
            decoded_reg   <= decoded_next;
        end
    end

    // the final pixel of an image sends the front back to expecting a header
    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.image_done) |=> (!in_packet_reg && decoded_reg == 32'd0))
        else $error("image end did not restart the front");

endmodule

/* design/trd_fifo.sv */
// short queue of finished pixels between the front and the back
// depends on trd_pkg for the item and status types
module trd_fifo
    import trd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  trd_item_t   push_item,
    input  logic        pop,
    output trd_item_t   pop_item,
    output trd_q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    trd_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !(push && !pop))
        else $error("push into a full pixel queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("pop from an empty pixel queue");

endmodule

/* design/trd_back.sv */
// back end: drains the pixel queue, places red and alpha, holds the output register
// depends on trd_pkg and trd_pixel_if
module trd_back
    import trd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  trd_item_t   q_item,
    input  trd_q_stat_t q_stat,
    output logic        pop,
    trd_pixel_if.source out_ch
);

    logic       out_valid_reg;
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg, rep_reg;
    logic       done_reg;

    assign pop = ~q_stat.empty & (~out_valid_reg | out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            blue_reg  <= q_item.blue;
            green_reg <= q_item.green;
            // 24-bit pixels end on red and carry no alpha byte
            red_reg   <= q_item.three_byte ? q_item.last_byte : q_item.byte2;
            alpha_reg <= q_item.three_byte ? OPAQUE_ALPHA : q_item.last_byte;
            rep_reg   <= q_item.repeat_count;
            done_reg  <= q_item.image_done;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.red          = red_reg;
    assign out_ch.green        = green_reg;
    assign out_ch.blue         = blue_reg;
    assign out_ch.alpha        = alpha_reg;
    assign out_ch.repeat_count = rep_reg;
    assign out_ch.image_done   = done_reg;

endmodule

/* design/tga_rle_pixel_decoder.sv */
// tga run-length pixel decoder, 24-bit and 32-bit true-color packets
// path: a pixel-completing byte's result is written into the queue, then into the output register, where it is valid
// throughput: one coded byte per cycle while the queue is not full, set by the front packet/pixel update
// the queue (QUEUE_DEPTH entries) lets the byte side run while a result waits to be taken
// reset: async active low; clears packet state, queue and output, pixel_bytes=4, total=1
module tga_rle_pixel_decoder
    import trd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    trd_cfg_if.sink     cfg,
    trd_byte_if.sink    coded,
    trd_pixel_if.source decoded
);

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [2:0]  pixel_bytes_reg;
    logic [31:0] total_pixels_reg;
    trd_cfg_t    cfg_now;

    // queue between byte-side front and pixel-side back
    logic        push;
    logic        pop;
    trd_item_t   push_item;
    trd_item_t   q_item;
    trd_q_stat_t q_stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg  <= PIXEL_BYTES_RESET;
            total_pixels_reg <= TOTAL_PIXELS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PIXEL_BYTES:  pixel_bytes_reg  <= cfg.data[2:0];
                REG_TOTAL_PIXELS: total_pixels_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign cfg_now.pixel_bytes  = pixel_bytes_reg;
    assign cfg_now.total_pixels = total_pixels_reg;

    // front: header decode, pixel assembly, run clipping against the image total
    trd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_now),
        .in_ch     (coded),
        .q_full    (q_stat.full),
        .push      (push),
        .push_item (push_item)
    );

    trd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (q_item),
        .stat      (q_stat)
    );

    // back: channel placement and output register
    trd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_item (q_item),
        .q_stat (q_stat),
        .pop    (pop),
        .out_ch (decoded)
    );

    // every result covers at least one image pixel
    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid |-> (decoded.repeat_count != 8'd0))
        else $error("decoded pixel with zero repeat count");

endmodule
